/* rtl/core/nrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrp_pkg
// Shared types and controller codes for the NRPN / RPN control change parser.
// ----------------------------------------------------------------------------
package nrp_pkg;

    localparam int unsigned IDX_W  = 3;   // parser_index width
    localparam int unsigned CC_W   = 7;   // controller number / value width
    localparam int unsigned CHAN_W = 4;   // MIDI channel width
    localparam int unsigned MAX_ADDR_CTX = 1 << IDX_W;

    // Controller numbers
    localparam logic [CC_W-1:0] CC_DATA_MSB  = 7'd6;
    localparam logic [CC_W-1:0] CC_DATA_LSB  = 7'd38;
    localparam logic [CC_W-1:0] CC_INCREMENT = 7'd96;
    localparam logic [CC_W-1:0] CC_DECREMENT = 7'd97;
    localparam logic [CC_W-1:0] CC_NRPN_LO   = 7'd98;
    localparam logic [CC_W-1:0] CC_NRPN_HI   = 7'd99;
    localparam logic [CC_W-1:0] CC_RPN_LO    = 7'd100;
    localparam logic [CC_W-1:0] CC_RPN_HI    = 7'd101;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PARAM_MSB = 3'd1,
        PH_PARAM_LSB = 3'd2,
        PH_DATA_MSB  = 3'd3,
        PH_COMPLETE  = 3'd4
    } t_phase;

    // One assembly context
    typedef struct packed {
        t_phase            phase;
        logic              is_reg;
        logic [CC_W-1:0]   param_hi;
        logic [CC_W-1:0]   param_lo;
        logic [CC_W-1:0]   data_hi;
        logic [CC_W-1:0]   data_lo;
        logic [CHAN_W-1:0] chan;
        logic              valid;
    } t_ctx;

    // Incoming control change
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [CC_W-1:0]   ctrl;
        logic [CC_W-1:0]   value;
        logic [CHAN_W-1:0] chan;
    } t_item;

    // One result
    typedef struct packed {
        logic                complete;
        logic                is_reg;
        logic [2*CC_W-1:0]   param_num;
        logic [2*CC_W-1:0]   data_val;
        logic [CHAN_W-1:0]   chan;
        t_phase              state;
        logic                valid;
    } t_result;

endpackage

/* rtl/core/midi_nrpn_rpn_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_nrpn_rpn_parser_core
// MIDI NRPN / RPN assembler over independent per-parser contexts.
// ----------------------------------------------------------------------------
// Each input transfer is one MIDI control change, steered by parser_index to
// one of NUM_CONTEXTS assembly contexts (indexes at or above NUM_CONTEXTS,
// or above 7, yield an all-zero result and touch nothing). Parameter MSB
// (99 NRPN / 101 RPN) opens a message; the matching LSB, data entry MSB/LSB
// and increment/decrement follow on the same channel. Every input transfer
// produces exactly one output transfer carrying the completion flag, the
// context state after the step and, while the stored message is valid, its
// type, 14-bit parameter, 14-bit data and channel. Throughput is one transfer
// per clock while the output stream does not stall; each transfer passes the
// input register, then the context read-modify-write that loads the output
// register. Reset clears all contexts at once.
// ----------------------------------------------------------------------------
module midi_nrpn_rpn_parser_core #(
    parameter int unsigned NUM_CONTEXTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // controller_number[6:0], controller_value[13:7],
                                     // midi_channel[17:14], zero fill
    input  logic [2:0]  i_s_tuser,   // parser_index[2:0]
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // parameter_number[13:0], data_value[27:14],
                                     // message_channel[31:28], parser_state[34:32],
                                     // zero fill
    output logic [2:0]  o_m_tuser    // complete[0], is_registered[1], msg_valid[2]
);
    import nrp_pkg::*;

    // only eight contexts are addressable by a 3-bit index
    localparam int unsigned DEPTH =
        (NUM_CONTEXTS < MAX_ADDR_CTX) ? NUM_CONTEXTS : MAX_ADDR_CTX;

    // input register stage
    logic    r_in_valid;
    t_item   r_item;

    // output register stage
    logic    r_out_valid;
    t_result r_res;

    logic    move;
    logic    hit;
    t_ctx    cur_ctx;
    t_ctx    nxt_ctx;
    t_result step_res;

    // advance input stage into output stage; context is written in the same edge
    assign move       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_item.idx   <= i_s_tuser;
            r_item.ctrl  <= i_s_tdata[6:0];
            r_item.value <= i_s_tdata[13:7];
            r_item.chan  <= i_s_tdata[17:14];
        end
    end

    nrp_ctx_file #(
        .DEPTH (DEPTH)
    ) u_ctx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_idx    (r_item.idx),
        .i_wr_en  (move),
        .i_wr_ctx (nxt_ctx),
        .o_rd_ctx (cur_ctx),
        .o_hit    (hit)
    );

    nrp_step u_step (
        .i_item (r_item),
        .i_cur  (cur_ctx),
        .i_hit  (hit),
        .o_nxt  (nxt_ctx),
        .o_res  (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_res <= step_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_res.state, r_res.chan, r_res.data_val, r_res.param_num};
    assign o_m_tuser  = {r_res.valid, r_res.is_reg, r_res.complete};

endmodule

/* rtl/core/nrp_ctx_file.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrp_ctx_file
// Register file of parser contexts: one read port, one write port, reset clear.
// ----------------------------------------------------------------------------
module nrp_ctx_file #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [nrp_pkg::IDX_W-1:0] i_idx,
    input  logic                      i_wr_en,
    input  nrp_pkg::t_ctx             i_wr_ctx,
    output nrp_pkg::t_ctx             o_rd_ctx,
    output logic                      o_hit
);
    import nrp_pkg::*;

    t_ctx r_ctx [DEPTH];

    // index compare per entry; out-of-range index hits nothing
    always_comb begin
        o_rd_ctx = '0;
        o_hit    = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            if (i_idx == IDX_W'(k)) begin
                o_rd_ctx = r_ctx[k];
                o_hit    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            if (!i_rst_n) begin
                r_ctx[k] <= '0;
            end else if (i_wr_en && (i_idx == IDX_W'(k))) begin
                r_ctx[k] <= i_wr_ctx;
            end
        end
    end

endmodule

/* rtl/core/nrp_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrp_step
// Next-context and result logic for one control change.
// ----------------------------------------------------------------------------
module nrp_step (
    input  nrp_pkg::t_item   i_item,
    input  nrp_pkg::t_ctx    i_cur,
    input  logic             i_hit,
    output nrp_pkg::t_ctx    o_nxt,
    output nrp_pkg::t_result o_res
);
    import nrp_pkg::*;

    logic done;
    logic chan_ok;

    assign chan_ok = (i_cur.chan == i_item.chan);

    always_comb begin
        o_nxt = i_cur;
        done  = 1'b0;
        if ((i_item.ctrl == CC_NRPN_HI) || (i_item.ctrl == CC_RPN_HI)) begin
            o_nxt.is_reg   = (i_item.ctrl == CC_RPN_HI);
            o_nxt.param_hi = i_item.value;
            o_nxt.phase    = PH_PARAM_MSB;
            o_nxt.chan     = i_item.chan;
            o_nxt.valid    = 1'b0;
        end else if ((i_item.ctrl == CC_NRPN_LO) || (i_item.ctrl == CC_RPN_LO)) begin
            if ((i_cur.phase == PH_PARAM_MSB) && chan_ok &&
                (i_cur.is_reg == (i_item.ctrl == CC_RPN_LO))) begin
                o_nxt.param_lo = i_item.value;
                o_nxt.phase    = PH_PARAM_LSB;
            end
        end else if (i_item.ctrl == CC_DATA_MSB) begin
            if ((i_cur.phase == PH_PARAM_LSB) && chan_ok) begin
                o_nxt.data_hi = i_item.value;
                o_nxt.phase   = PH_DATA_MSB;
            end
        end else if (i_item.ctrl == CC_DATA_LSB) begin
            if (((i_cur.phase == PH_PARAM_LSB) || (i_cur.phase == PH_DATA_MSB)) &&
                chan_ok) begin
                o_nxt.data_lo = i_item.value;
                o_nxt.phase   = PH_COMPLETE;
                o_nxt.valid   = 1'b1;
                done          = 1'b1;
            end
        end else if ((i_item.ctrl == CC_INCREMENT) || (i_item.ctrl == CC_DECREMENT)) begin
            // completes with the data last stored
            if ((i_cur.phase == PH_PARAM_LSB) && chan_ok) begin
                o_nxt.phase = PH_COMPLETE;
                o_nxt.valid = 1'b1;
                done        = 1'b1;
            end
        end
    end

    always_comb begin
        o_res = '0;
        if (i_hit) begin
            o_res.complete = done;
            o_res.state    = o_nxt.phase;
            o_res.valid    = o_nxt.valid;
            if (o_nxt.valid) begin
                o_res.is_reg    = o_nxt.is_reg;
                o_res.param_num = {o_nxt.param_hi, o_nxt.param_lo};
                o_res.data_val  = {o_nxt.data_hi, o_nxt.data_lo};
                o_res.chan      = o_nxt.chan;
            end
        end
    end

endmodule

/* test/tb_midi_nrpn_rpn_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_nrpn_rpn_parser_core
// Self-checking bench for the NRPN / RPN control change parser.
// ----------------------------------------------------------------------------
// Control changes go in on the slave stream. Every accepted transfer is run
// through a per-context message tracker that predicts the one result it
// causes. Results on the master stream are compared field by field, in
// order. A short directed part covers the sequence rules and corner cases.
// The random part follows: mostly well-formed messages with random content,
// some of them broken, mixed with stray controllers on random contexts.
// Both streams idle in random bursts except near the end.
// ----------------------------------------------------------------------------
module tb_midi_nrpn_rpn_parser_core;

    import nrp_pkg::*;

    localparam int unsigned CONTEXTS     = 8;
    localparam int unsigned RANDOM_ITEMS = 1600;
    localparam int unsigned CALM_ITEMS   = 300;   // tail of the run with no idling
    localparam int unsigned HOLD_AT      = 800;   // sender waits for all results here
    localparam int unsigned STALL_LIMIT  = 1000;  // cycles with no transfer at all

    // ------------------------------------------------------------------------
    // Message tracker: mirrors every assembly context and keeps the results
    // still owed by the block, oldest first.
    // ------------------------------------------------------------------------
    class cc_message_tracker;
        t_ctx        ctx_mem[CONTEXTS];
        t_result     owed_results[$];
        int unsigned mismatches;

        function new();
            foreach (ctx_mem[k]) begin
                ctx_mem[k] = '0;
                ctx_mem[k].phase = PH_IDLE;
            end
            mismatches = 0;
        endfunction

        // One control change through its context; returns the result it causes.
        function t_result assemble(t_item it);
            t_result r;
            t_ctx    c;
            r = '0;
            r.state = PH_IDLE;
            if (it.idx >= CONTEXTS)
                return r;
            c = ctx_mem[it.idx];
            case (it.ctrl)
                CC_NRPN_HI, CC_RPN_HI: begin
                    c.is_reg   = (it.ctrl == CC_RPN_HI);
                    c.param_hi = it.value;
                    c.phase    = PH_PARAM_MSB;
                    c.chan     = it.chan;
                    c.valid    = 1'b0;
                end
                CC_NRPN_LO, CC_RPN_LO: begin
                    if (c.phase == PH_PARAM_MSB && c.is_reg == (it.ctrl == CC_RPN_LO) &&
                        c.chan == it.chan) begin
                        c.param_lo = it.value;
                        c.phase    = PH_PARAM_LSB;
                    end
                end
                CC_DATA_MSB: begin
                    if (c.phase == PH_PARAM_LSB && c.chan == it.chan) begin
                        c.data_hi = it.value;
                        c.phase   = PH_DATA_MSB;
                    end
                end
                CC_DATA_LSB: begin
                    if ((c.phase == PH_PARAM_LSB || c.phase == PH_DATA_MSB) &&
                        c.chan == it.chan) begin
                        c.data_lo  = it.value;
                        c.phase    = PH_COMPLETE;
                        c.valid    = 1'b1;
                        r.complete = 1'b1;
                    end
                end
                CC_INCREMENT, CC_DECREMENT: begin
                    // completes with the data last stored
                    if (c.phase == PH_PARAM_LSB && c.chan == it.chan) begin
                        c.phase    = PH_COMPLETE;
                        c.valid    = 1'b1;
                        r.complete = 1'b1;
                    end
                end
                default: ;
            endcase
            ctx_mem[it.idx] = c;
            r.state = c.phase;
            r.valid = c.valid;
            if (c.valid) begin
                r.is_reg    = c.is_reg;
                r.param_num = {c.param_hi, c.param_lo};
                r.data_val  = {c.data_hi, c.data_lo};
                r.chan      = c.chan;
            end
            return r;
        endfunction

        function void note_cc(t_item it);
            owed_results.push_back(assemble(it));
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                $error("result with nothing expected");
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            compare("complete", want.complete, got.complete);
            compare("is_registered", want.is_reg, got.is_reg);
            compare("parameter_number", want.param_num, got.param_num);
            compare("data_value", want.data_val, got.data_val);
            compare("message_channel", want.chan, got.chan);
            compare("parser_state", want.state, got.state);
            compare("msg_valid", want.valid, got.valid);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block hookup
    // ------------------------------------------------------------------------
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;   // controller_number, controller_value, midi_channel
    logic [2:0]  i_s_tuser  = '0;   // parser_index
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;         // parameter_number, data_value, channel, state
    logic [2:0]  o_m_tuser;         // complete, is_registered, msg_valid

    midi_nrpn_rpn_parser_core #(
        .NUM_CONTEXTS(CONTEXTS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    cc_message_tracker tracker = new();

    bit          idle_enable = 1'b1;  // random idling on both streams
    int unsigned items_sent  = 0;

    // ------------------------------------------------------------------------
    // Monitors. They run at the rising edge and read the values from before
    // it, since all stimulus is driven with nonblocking assignments.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : in_monitor
        t_item seen;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            seen.idx   = i_s_tuser;
            seen.ctrl  = i_s_tdata[6:0];
            seen.value = i_s_tdata[13:7];
            seen.chan  = i_s_tdata[17:14];
            tracker.note_cc(seen);
        end
    end

    always @(posedge i_clk) begin : out_monitor
        t_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.param_num = o_m_tdata[13:0];
            got.data_val  = o_m_tdata[27:14];
            got.chan      = o_m_tdata[31:28];
            got.state     = t_phase'(o_m_tdata[34:32]);
            got.complete  = o_m_tuser[0];
            got.is_reg    = o_m_tuser[1];
            got.valid     = o_m_tuser[2];
            tracker.check_result(got);
        end
    end

    // Receiver back-pressure: random stalls.
    always @(posedge i_clk) begin : sink
        int stall_left;
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog: too long with no transfer on either stream means a hang.
    always @(posedge i_clk) begin : watchdog
        int unsigned quiet;
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("midi_nrpn_rpn_parser_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    // One control change; returns once the transfer has been taken.
    task automatic send_cc(logic [2:0] idx, logic [6:0] ctrl, logic [6:0] value,
                           logic [3:0] chan);
        int unsigned gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, chan, value, ctrl};
        i_s_tuser  <= idx;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop sending and let every owed result come back.
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.owed_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [2:0] idx;
        logic [3:0] chan;
        logic [3:0] step_chan;
        logic [6:0] lsb_ctrl;
        logic [6:0] finish_ctrl;
        bit         rpn;
        bit         broken;
        bit         held;
        int unsigned pick;

        held = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        // data entry and increment on an idle context: ignored
        send_cc(3'd0, CC_DATA_LSB, 7'd55, 4'd0);
        send_cc(3'd0, CC_INCREMENT, 7'd0, 4'd0);
        // full NRPN at the value extremes
        send_cc(3'd0, CC_NRPN_HI, 7'd0, 4'd0);
        send_cc(3'd0, CC_NRPN_LO, 7'd0, 4'd0);
        send_cc(3'd0, CC_DATA_MSB, 7'd127, 4'd0);
        send_cc(3'd0, CC_DATA_LSB, 7'd127, 4'd0);
        // RPN on the top context and channel, closed by increment: data stays 0
        send_cc(3'd7, CC_RPN_HI, 7'd127, 4'd15);
        send_cc(3'd7, CC_RPN_LO, 7'd127, 4'd15);
        send_cc(3'd7, CC_INCREMENT, 7'd33, 4'd15);
        // wrong type and wrong channel LSBs are dropped, then decrement closes
        send_cc(3'd3, CC_NRPN_HI, 7'd5, 4'd2);
        send_cc(3'd3, CC_RPN_LO, 7'd9, 4'd2);
        send_cc(3'd3, CC_NRPN_LO, 7'd9, 4'd3);
        send_cc(3'd3, CC_NRPN_LO, 7'd9, 4'd2);
        send_cc(3'd3, CC_DECREMENT, 7'd1, 4'd2);
        // data LSB after completion: ignored
        send_cc(3'd3, CC_DATA_LSB, 7'd70, 4'd2);
        // completion straight after the parameter LSB, no data MSB
        send_cc(3'd5, CC_RPN_HI, 7'd1, 4'd9);
        send_cc(3'd5, CC_RPN_LO, 7'd2, 4'd9);
        send_cc(3'd5, CC_DATA_LSB, 7'd3, 4'd9);
        // unrelated controllers leave the stored message alone
        send_cc(3'd0, 7'd7, 7'd100, 4'd0);
        send_cc(3'd0, 7'd127, 7'd127, 4'd15);
        send_cc(3'd0, 7'd0, 7'd0, 4'd0);
        // a new parameter MSB drops the valid mark
        send_cc(3'd0, CC_NRPN_HI, 7'd64, 4'd8);

        // Sender holds off until the block has answered everything.
        wait_for_results();

        // --- random part ---
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= RANDOM_ITEMS - CALM_ITEMS)
                idle_enable = 1'b0;
            if (!held && items_sent >= HOLD_AT) begin
                held = 1'b1;
                wait_for_results();
            end

            if ($urandom_range(0, 9) < 7) begin
                // well-formed message with random content, sometimes bent
                idx    = 3'($urandom_range(0, 7));
                chan   = 4'($urandom_range(0, 15));
                rpn    = 1'($urandom_range(0, 1));
                broken = ($urandom_range(0, 7) == 0);
                send_cc(idx, rpn ? CC_RPN_HI : CC_NRPN_HI, 7'($urandom), chan);

                lsb_ctrl  = rpn ? CC_RPN_LO : CC_NRPN_LO;
                step_chan = chan;
                if (broken) begin
                    pick = $urandom_range(0, 1);
                    if (pick == 0)
                        lsb_ctrl = rpn ? CC_NRPN_LO : CC_RPN_LO;
                    else
                        step_chan = chan ^ 4'($urandom_range(1, 15));
                end
                // another context's traffic may slip in between
                if ($urandom_range(0, 5) == 0)
                    send_cc(3'($urandom_range(0, 7)), 7'($urandom), 7'($urandom),
                            4'($urandom));
                send_cc(idx, lsb_ctrl, 7'($urandom), step_chan);

                if ($urandom_range(0, 9) < 6)
                    send_cc(idx, CC_DATA_MSB, 7'($urandom), chan);

                pick = $urandom_range(0, 9);
                if (pick < 5)
                    finish_ctrl = CC_DATA_LSB;
                else if (pick < 7)
                    finish_ctrl = CC_INCREMENT;
                else if (pick < 9)
                    finish_ctrl = CC_DECREMENT;
                else
                    finish_ctrl = 7'd0;   // message abandoned
                if (finish_ctrl != 7'd0)
                    send_cc(idx, finish_ctrl, 7'($urandom), chan);
            end else begin
                // noise: sequence controllers out of place or anything else
                pick = $urandom_range(0, 7);
                case (pick)
                    0: finish_ctrl = CC_DATA_MSB;
                    1: finish_ctrl = CC_DATA_LSB;
                    2: finish_ctrl = CC_INCREMENT;
                    3: finish_ctrl = CC_DECREMENT;
                    4: finish_ctrl = CC_NRPN_LO;
                    5: finish_ctrl = CC_RPN_LO;
                    default: finish_ctrl = 7'($urandom);
                endcase
                send_cc(3'($urandom_range(0, 7)), finish_ctrl, 7'($urandom),
                        4'($urandom));
            end
        end

        // --- drain ---
        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("midi_nrpn_rpn_parser_core: match");
        else
            $display("midi_nrpn_rpn_parser_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/nrp_pkg.sv
rtl/core/nrp_ctx_file.sv
rtl/core/nrp_step.sv
rtl/core/midi_nrpn_rpn_parser_core.sv
test/tb_midi_nrpn_rpn_parser_core.sv
